FILE: hw/rtl/crfb_pkg.sv
// Package with the codes, flag positions and beat layouts of the card reader flag and buffer block.
package crfb_pkg;

    localparam int FLAG_COUNT = 12;
    localparam int HEAD_W = 6;
    localparam int WORD_W = 28;

    localparam int FL_BUFFER_READY = 0;
    localparam int FL_MOTOR = 9;
    localparam int FL_CARD_IN = 10;

    localparam logic [6:0] OP_LOW_SET = 7'o000;
    localparam logic [6:0] OP_LOW_TEST = 7'o100;
    localparam logic [6:0] OP_LOW_SET_HI = 7'o060;
    localparam logic [6:0] OP_LOW_TEST_HI = 7'o160;
    localparam logic [2:0] OP_HI_LIMIT = 3'd3;

    typedef enum logic [2:0] {
        FN_INSTR = 3'd0,
        FN_EXT_FLAG = 3'd1,
        FN_INSERT = 3'd2,
        FN_READ = 3'd3,
        FN_WRITE = 3'd4,
        FN_RESET = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_CARD = 3'd1,
        ST_MOTOR_OFF = 3'd2,
        ST_PAST_END = 3'd3,
        ST_PROTECTED = 3'd4,
        ST_CARD_PRESENT = 3'd5,
        ST_MOTOR_RUNNING = 3'd6,
        ST_UNKNOWN_OP = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        OPK_NONE = 2'd0,
        OPK_SET = 2'd1,
        OPK_TEST = 2'd2
    } t_op_kind;

    typedef struct packed {
        logic [WORD_W-1:0] c_high_digits;
        logic [WORD_W-1:0] card_word;
        logic              card_protect;
        logic              flag_value;
        logic [3:0]        flag_index;
        logic [9:0]        opcode;
    } t_in_data;

    typedef struct packed {
        logic              card_done;
        logic              card_present;
        logic              buffer_ready;
        logic [4:0]        word_index;
        logic [WORD_W-1:0] write_word;
        logic [2*WORD_W-1:0] c_digits;
        logic              flag_was_set;
        t_status           status;
    } t_out_data;

    typedef struct packed {
        logic write_valid;
        logic read_valid;
    } t_out_user;

endpackage

FILE: hw/rtl/card_reader_flag_and_buffer_top.sv
// Top level of the card reader flag and buffer block.
//
// One beat on the slave channel carries one processor step: the function code in
// i_s_tuser and its operands in i_s_tdata. Each accepted beat yields exactly one
// result beat on the master channel, with the status, the flag test result, the
// read and write data, the head position and the buffer and card marks.
// A beat is first held in an input register; when the result register is free or
// is being read, its result is computed from that register and the flag, card and
// head state, and it is written to the result register while the state is
// updated. One beat is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result waits in its register, the input register
// still takes one more beat, and o_s_tready drops only while both are full.
// Synchronous reset clears all flags, the card, lock and head state, and both
// valid marks; no beat is in flight after reset. The reset function code clears
// only the internal flags.
module card_reader_flag_and_buffer_top #(
    parameter int CARD_WORDS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // opcode, flag_index, flag_value, card_protect, card_word, c_high_digits
    input  logic [71:0]  i_s_tdata,
    // func
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status, flag_was_set, c_digits, write_word, word_index, buffer_ready,
    // card_present, card_done
    output logic [95:0]  o_m_tdata,
    // read_valid, write_valid
    output logic [1:0]   o_m_tuser
);

    localparam int FC = crfb_pkg::FLAG_COUNT;
    localparam int HW = crfb_pkg::HEAD_W;
    localparam logic [HW-1:0] LP_CARD_WORDS = HW'(CARD_WORDS);

    logic                 r_in_valid;
    crfb_pkg::t_in_data   r_in;
    logic [2:0]           r_in_func;
    logic                 r_out_valid;
    crfb_pkg::t_out_data  r_out;
    crfb_pkg::t_out_user  r_out_user;

    logic [FC-1:0]        r_local_flags;
    logic [FC-1:0]        r_ext_flags;
    logic                 r_card_loaded;
    logic                 r_card_locked;
    logic [HW-1:0]        r_head_slot;

    logic [FC-1:0]        n_local_flags;
    logic [FC-1:0]        n_ext_flags;
    logic                 n_card_loaded;
    logic                 n_card_locked;
    logic [HW-1:0]        n_head_slot;
    crfb_pkg::t_out_data  n_out;
    crfb_pkg::t_out_user  n_out_user;

    logic                 advance;
    logic                 motor;
    logic [6:0]           op_low;
    logic [2:0]           op_hi;
    logic [3:0]           op_flag;
    crfb_pkg::t_op_kind   op_kind;
    logic [15:0]          local_wide;
    logic [15:0]          ext_wide;
    logic [15:0]          flag_bit;
    logic                 do_refresh;

    assign advance = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out;
    assign o_m_tuser = r_out_user;

    assign motor = r_local_flags[crfb_pkg::FL_MOTOR];
    assign op_low = r_in.opcode[6:0];
    assign op_hi = r_in.opcode[9:7];
    assign op_flag = {1'b0, op_hi} + {r_in.opcode[4], 3'b000};
    assign local_wide = {{(16-FC){1'b0}}, r_local_flags};
    assign ext_wide = {{(16-FC){1'b0}}, r_ext_flags};
    assign flag_bit = 16'(1) << op_flag;

    always_comb begin
        if (op_low == crfb_pkg::OP_LOW_SET && op_hi != 3'd0) begin
            op_kind = crfb_pkg::OPK_SET;
        end else if (op_low == crfb_pkg::OP_LOW_TEST) begin
            op_kind = crfb_pkg::OPK_TEST;
        end else if (op_low == crfb_pkg::OP_LOW_SET_HI && op_hi <= crfb_pkg::OP_HI_LIMIT) begin
            op_kind = crfb_pkg::OPK_SET;
        end else if (op_low == crfb_pkg::OP_LOW_TEST_HI && op_hi <= crfb_pkg::OP_HI_LIMIT) begin
            op_kind = crfb_pkg::OPK_TEST;
        end else begin
            op_kind = crfb_pkg::OPK_NONE;
        end
    end

    always_comb begin
        n_local_flags = r_local_flags;
        n_ext_flags = r_ext_flags;
        n_card_loaded = r_card_loaded;
        n_card_locked = r_card_locked;
        n_head_slot = r_head_slot;
        n_out = '0;
        n_out_user = '0;
        do_refresh = 1'b0;

        case (r_in_func)
            crfb_pkg::FN_INSTR: begin
                case (op_kind)
                    crfb_pkg::OPK_SET: begin
                        n_local_flags = FC'(local_wide | flag_bit);
                    end
                    crfb_pkg::OPK_TEST: begin
                        n_out.flag_was_set = |((local_wide | ext_wide) & flag_bit);
                        n_local_flags = FC'(local_wide & ~flag_bit);
                    end
                    default: begin
                        n_out.status = crfb_pkg::ST_UNKNOWN_OP;
                    end
                endcase
            end
            crfb_pkg::FN_EXT_FLAG: begin
                if (r_in.flag_index < 4'(FC)) begin
                    n_ext_flags[r_in.flag_index] = r_in.flag_value;
                end
            end
            crfb_pkg::FN_INSERT: begin
                if (r_card_loaded) begin
                    n_out.status = crfb_pkg::ST_CARD_PRESENT;
                end else if (motor) begin
                    n_out.status = crfb_pkg::ST_MOTOR_RUNNING;
                end else begin
                    n_card_loaded = 1'b1;
                    n_card_locked = r_in.card_protect;
                    n_head_slot = '0;
                    n_local_flags[crfb_pkg::FL_CARD_IN] = 1'b1;
                    do_refresh = 1'b1;
                end
            end
            crfb_pkg::FN_READ: begin
                if (!r_card_loaded) begin
                    n_out.status = crfb_pkg::ST_NO_CARD;
                end else if (!motor) begin
                    n_out.status = crfb_pkg::ST_MOTOR_OFF;
                end else if (r_head_slot >= LP_CARD_WORDS) begin
                    n_out.status = crfb_pkg::ST_PAST_END;
                end else begin
                    n_out.c_digits = {r_in.card_word, r_in.card_word};
                    n_out_user.read_valid = 1'b1;
                    n_out.word_index = r_head_slot[4:0];
                    n_head_slot = r_head_slot + HW'(1);
                    do_refresh = 1'b1;
                end
            end
            crfb_pkg::FN_WRITE: begin
                if (!r_card_loaded) begin
                    n_out.status = crfb_pkg::ST_NO_CARD;
                end else if (r_card_locked) begin
                    n_out.status = crfb_pkg::ST_PROTECTED;
                end else if (!motor) begin
                    n_out.status = crfb_pkg::ST_MOTOR_OFF;
                end else if (r_head_slot >= LP_CARD_WORDS) begin
                    n_out.status = crfb_pkg::ST_PAST_END;
                end else begin
                    n_out.write_word = r_in.c_high_digits;
                    n_out_user.write_valid = 1'b1;
                    n_out.word_index = r_head_slot[4:0];
                    n_head_slot = r_head_slot + HW'(1);
                    do_refresh = 1'b1;
                end
            end
            crfb_pkg::FN_RESET: begin
                n_local_flags = '0;
            end
            default: begin
            end
        endcase

        if (do_refresh) begin
            n_local_flags[crfb_pkg::FL_BUFFER_READY] = n_card_loaded
                && n_local_flags[crfb_pkg::FL_MOTOR] && (n_head_slot < LP_CARD_WORDS);
            if (n_card_loaded && n_head_slot >= LP_CARD_WORDS) begin
                n_card_loaded = 1'b0;
                n_card_locked = 1'b0;
                n_head_slot = '0;
                n_out.card_done = 1'b1;
            end
        end

        n_out.buffer_ready = n_local_flags[crfb_pkg::FL_BUFFER_READY];
        n_out.card_present = n_card_loaded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_local_flags <= '0;
            r_ext_flags <= '0;
            r_card_loaded <= 1'b0;
            r_card_locked <= 1'b0;
            r_head_slot <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_local_flags <= n_local_flags;
                r_ext_flags <= n_ext_flags;
                r_card_loaded <= n_card_loaded;
                r_card_locked <= n_card_locked;
                r_head_slot <= n_head_slot;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= i_s_tdata;
            r_in_func <= i_s_tuser;
        end
        if (advance) begin
            r_out <= n_out;
            r_out_user <= n_out_user;
        end
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the card reader flag and buffer block.
`timescale 1ns / 1ps

module tb_top;

    localparam int CARD_WORDS = 32;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        crfb_pkg::t_out_data d;
        crfb_pkg::t_out_user u;
    } t_card_result;

    class card_step_tracker;
        logic [15:0] lflags;
        logic [15:0] eflags;
        logic loaded;
        logic locked;
        logic [5:0] head;
        t_card_result awaited[$];
        int errors;
        int n_read;
        int n_write;
        int n_eject;
        int n_test_hit;
        int status_seen[8];

        function new();
            lflags = '0;
            eflags = '0;
            loaded = 1'b0;
            locked = 1'b0;
            head = '0;
            errors = 0;
            n_read = 0;
            n_write = 0;
            n_eject = 0;
            n_test_hit = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Buffer ready follows motor, card and head; passing the last word ejects the card.
        function logic settle_head();
            lflags[crfb_pkg::FL_BUFFER_READY] = loaded && lflags[crfb_pkg::FL_MOTOR]
                && (head < CARD_WORDS);
            if (loaded && head >= CARD_WORDS) begin
                loaded = 1'b0;
                locked = 1'b0;
                head = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_step(logic [2:0] fn, crfb_pkg::t_in_data d);
            t_card_result r;
            crfb_pkg::t_status st;
            crfb_pkg::t_op_kind kind;
            logic motor;
            logic [6:0] low;
            logic [2:0] hi;
            logic [3:0] fl;
            r = '0;
            st = crfb_pkg::ST_OK;
            motor = lflags[crfb_pkg::FL_MOTOR];
            case (fn)
                crfb_pkg::FN_INSTR: begin
                    low = d.opcode[6:0];
                    hi = d.opcode[9:7];
                    fl = {1'b0, hi} + {d.opcode[4], 3'b000};
                    if (low == crfb_pkg::OP_LOW_SET && hi != 3'd0)
                        kind = crfb_pkg::OPK_SET;
                    else if (low == crfb_pkg::OP_LOW_TEST)
                        kind = crfb_pkg::OPK_TEST;
                    else if (low == crfb_pkg::OP_LOW_SET_HI && hi <= crfb_pkg::OP_HI_LIMIT)
                        kind = crfb_pkg::OPK_SET;
                    else if (low == crfb_pkg::OP_LOW_TEST_HI && hi <= crfb_pkg::OP_HI_LIMIT)
                        kind = crfb_pkg::OPK_TEST;
                    else
                        kind = crfb_pkg::OPK_NONE;
                    if (kind == crfb_pkg::OPK_SET) begin
                        lflags[fl] = 1'b1;
                    end else if (kind == crfb_pkg::OPK_TEST) begin
                        r.d.flag_was_set = lflags[fl] | eflags[fl];
                        lflags[fl] = 1'b0;
                    end else begin
                        st = crfb_pkg::ST_UNKNOWN_OP;
                    end
                end
                crfb_pkg::FN_EXT_FLAG: begin
                    if (d.flag_index < crfb_pkg::FLAG_COUNT)
                        eflags[d.flag_index] = d.flag_value;
                end
                crfb_pkg::FN_INSERT: begin
                    if (loaded) st = crfb_pkg::ST_CARD_PRESENT;
                    else if (motor) st = crfb_pkg::ST_MOTOR_RUNNING;
                    else begin
                        loaded = 1'b1;
                        locked = d.card_protect;
                        head = '0;
                        lflags[crfb_pkg::FL_CARD_IN] = 1'b1;
                        r.d.card_done = settle_head();
                    end
                end
                crfb_pkg::FN_READ: begin
                    if (!loaded) st = crfb_pkg::ST_NO_CARD;
                    else if (!motor) st = crfb_pkg::ST_MOTOR_OFF;
                    else if (head >= CARD_WORDS) st = crfb_pkg::ST_PAST_END;
                    else begin
                        r.d.c_digits = {d.card_word, d.card_word};
                        r.u.read_valid = 1'b1;
                        r.d.word_index = head[4:0];
                        head = head + 6'd1;
                        r.d.card_done = settle_head();
                        n_read++;
                    end
                end
                crfb_pkg::FN_WRITE: begin
                    if (!loaded) st = crfb_pkg::ST_NO_CARD;
                    else if (locked) st = crfb_pkg::ST_PROTECTED;
                    else if (!motor) st = crfb_pkg::ST_MOTOR_OFF;
                    else if (head >= CARD_WORDS) st = crfb_pkg::ST_PAST_END;
                    else begin
                        r.d.write_word = d.c_high_digits;
                        r.u.write_valid = 1'b1;
                        r.d.word_index = head[4:0];
                        head = head + 6'd1;
                        r.d.card_done = settle_head();
                        n_write++;
                    end
                end
                crfb_pkg::FN_RESET: begin
                    lflags = '0;
                end
                default: begin
                end
            endcase
            lflags[15:12] = 4'b0;
            r.d.status = st;
            r.d.buffer_ready = lflags[crfb_pkg::FL_BUFFER_READY];
            r.d.card_present = loaded;
            status_seen[st]++;
            if (r.d.card_done) n_eject++;
            if (r.d.flag_was_set) n_test_hit++;
            awaited.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(crfb_pkg::t_out_data gd, crfb_pkg::t_out_user gu);
            t_card_result e;
            if (awaited.size() == 0) begin
                $error("result beat arrived with no step awaiting it");
                errors++;
                return;
            end
            e = awaited.pop_front();
            cmp("status", e.d.status, gd.status);
            cmp("flag_was_set", e.d.flag_was_set, gd.flag_was_set);
            cmp("c_digits", e.d.c_digits, gd.c_digits);
            cmp("read_valid", e.u.read_valid, gu.read_valid);
            cmp("write_word", e.d.write_word, gd.write_word);
            cmp("write_valid", e.u.write_valid, gu.write_valid);
            cmp("word_index", e.d.word_index, gd.word_index);
            cmp("buffer_ready", e.d.buffer_ready, gd.buffer_ready);
            cmp("card_present", e.d.card_present, gd.card_present);
            cmp("card_done", e.d.card_done, gd.card_done);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [71:0]  i_s_tdata;
    logic [2:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;

    card_step_tracker tracker;
    int n_sent;
    int burst_left;
    int idle_cycles;

    card_reader_flag_and_buffer_top #(
        .CARD_WORDS(CARD_WORDS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function crfb_pkg::t_in_data rand_data();
        crfb_pkg::t_in_data d;
        d.opcode = 10'($urandom_range(0, 1023));
        d.flag_index = 4'($urandom_range(0, 15));
        d.flag_value = 1'($urandom_range(0, 1));
        d.card_protect = 1'($urandom_range(0, 1));
        d.card_word = 28'($urandom);
        d.c_high_digits = 28'($urandom);
        return d;
    endfunction

    function logic [9:0] flag_op(bit clear, int fl);
        if (fl < 8)
            return {3'(fl), clear ? crfb_pkg::OP_LOW_TEST : crfb_pkg::OP_LOW_SET};
        return {3'(fl - 8), clear ? crfb_pkg::OP_LOW_TEST_HI : crfb_pkg::OP_LOW_SET_HI};
    endfunction

    task automatic send_item(input logic [2:0] fn, input crfb_pkg::t_in_data d);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata <= d;
        i_s_tuser <= fn;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_step(fn, d);
        n_sent++;
    endtask

    task automatic send_op(input logic [9:0] op);
        crfb_pkg::t_in_data d;
        d = rand_data();
        d.opcode = op;
        send_item(crfb_pkg::FN_INSTR, d);
    endtask

    task automatic send_ext(input int idx, input logic val);
        crfb_pkg::t_in_data d;
        d = rand_data();
        d.flag_index = 4'(idx);
        d.flag_value = val;
        send_item(crfb_pkg::FN_EXT_FLAG, d);
    endtask

    task automatic send_noise();
        crfb_pkg::t_in_data d;
        d = rand_data();
        if ($urandom_range(0, 1))
            d.opcode = flag_op(1'($urandom_range(0, 1)), $urandom_range(0, 11));
        send_item(3'($urandom_range(0, 7)), d);
    endtask

    initial begin
        int r;
        int len;
        i_m_tready <= 1'b1;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                i_m_tready <= 1'b1;
                len = $urandom_range(30, 120);
            end else if (r < 60) begin
                i_m_tready <= 1'b1;
                len = $urandom_range(1, 4);
            end else if (r < 92) begin
                i_m_tready <= 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                i_m_tready <= 1'b0;
                len = $urandom_range(10, 50);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_result(crfb_pkg::t_out_data'(o_m_tdata),
                                 crfb_pkg::t_out_user'(o_m_tuser));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        crfb_pkg::t_in_data d;
        int sessions;
        int accesses;
        int target;
        tracker = new();
        n_sent = 0;
        burst_left = 0;
        sessions = 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(crfb_pkg::FN_READ, rand_data());
        send_item(crfb_pkg::FN_WRITE, rand_data());
        send_op(flag_op(1'b0, crfb_pkg::FL_MOTOR));
        send_item(crfb_pkg::FN_INSERT, rand_data());
        send_op(flag_op(1'b1, crfb_pkg::FL_MOTOR));
        send_ext(3, 1'b1);
        send_ext(15, 1'b1);
        send_ext(12, 1'b1);
        send_op(flag_op(1'b1, 3));
        send_op(10'h3FF);
        send_op(10'h000);
        d = rand_data();
        d.card_protect = 1'b1;
        send_item(crfb_pkg::FN_INSERT, d);
        send_item(crfb_pkg::FN_INSERT, rand_data());
        send_item(crfb_pkg::FN_READ, rand_data());
        send_item(crfb_pkg::FN_WRITE, rand_data());
        send_op(flag_op(1'b0, crfb_pkg::FL_MOTOR));
        d = rand_data();
        d.card_word = '1;
        d.c_high_digits = '1;
        send_item(crfb_pkg::FN_READ, d);
        d.card_word = '0;
        d.c_high_digits = '0;
        send_item(crfb_pkg::FN_READ, d);
        send_op(flag_op(1'b0, 7));
        send_op(flag_op(1'b1, 7));
        send_op(flag_op(1'b0, 11));
        send_op(flag_op(1'b1, 11));
        send_item(crfb_pkg::FN_RESET, rand_data());
        send_item(3'd6, rand_data());
        send_item(3'd7, rand_data());
        send_ext(3, 1'b0);

        target = RANDOM_ITEMS;
        while (n_sent < target) begin
            sessions++;
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(10, 30)) send_noise();
            end else begin
                if (!tracker.loaded) begin
                    if ($urandom_range(0, 1)) send_op(flag_op(1'b1, crfb_pkg::FL_MOTOR));
                    else send_item(crfb_pkg::FN_RESET, rand_data());
                    d = rand_data();
                    d.card_protect = ($urandom_range(0, 3) == 0);
                    send_item(crfb_pkg::FN_INSERT, d);
                end
                send_op(flag_op(1'b0, crfb_pkg::FL_MOTOR));
                accesses = $urandom_range(20, 45);
                repeat (accesses) begin
                    if ($urandom_range(0, 4) == 0) send_noise();
                    else send_item($urandom_range(0, 1) ? crfb_pkg::FN_READ
                                                        : crfb_pkg::FN_WRITE, rand_data());
                end
            end
            if (sessions == 2 || $urandom_range(0, 9) == 0) begin
                i_s_tvalid <= 1'b0;
                while (tracker.awaited.size() != 0) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d steps: %0d reads, %0d writes, %0d card ejects, %0d test hits",
                 n_sent, tracker.n_read, tracker.n_write, tracker.n_eject, tracker.n_test_hit);
        $display("codes ok/nocard/motoroff/pastend/prot/present/running/unknown: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
                 tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5],
                 tracker.status_seen[6], tracker.status_seen[7]);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
